>>> rtl/nhrf_pkg.sv
package nhrf_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       frame_first;
    logic       frame_last;
    logic       frame_abort;
    logic [2:0] event_res;
  } out_item_t;

  localparam logic       FUNC_BYTE    = 1'b0;
  localparam logic       FUNC_RESTART = 1'b1;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_STATUS_OK = 3'd1;
  localparam logic [2:0] EV_PREAMBLE  = 3'd2;
  localparam logic [2:0] EV_REJECT    = 3'd3;
  localparam logic [2:0] EV_TOO_LONG  = 3'd4;

  localparam logic [7:0] PREAMBLE     = 8'hD3;
  localparam logic [7:0] LEN_HI_MASK  = 8'h03;
  localparam int         FRAME_EXTRA  = 6;
  localparam int         WIN_LEN      = 12;

  localparam logic [55:0] ICY_TEXT    = "ICY 200";
  localparam logic [95:0] HTTP11_TEXT = "HTTP/1.1 200";
  localparam logic [95:0] HTTP10_TEXT = "HTTP/1.0 200";
  localparam logic [31:0] TERM_TEXT   = 32'h0D0A_0D0A;

endpackage

>>> rtl/ntrip_handshake_rtcm3_framer.sv
// Caster response handshake and RTCM3 frame splitter. Each input item is one
// stream byte (func 0) or a restart (func 1). Every item is decided in the
// cycle it is accepted and lands in a single output register, so the block
// takes one item per clock; in_ready is high whenever that register is empty
// or its item is being taken in the same cycle, so only a stalled output
// slows the input. Items that cause nothing (dropped bytes, plain header
// bytes) yield no output item. Header bytes are counted up to HEADER_MAX;
// frame bytes carry first and last marks, and a restart during a frame
// yields one item with frame_abort set.
module ntrip_handshake_rtcm3_framer
  import nhrf_pkg::*;
#(
  parameter int HEADER_MAX = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW = $clog2(HEADER_MAX + 1);

  logic                   header_phase, header_phase_next;
  logic [CW-1:0]          header_count, header_count_next;
  logic [WIN_LEN*8-1:0]   tail_window, tail_window_next;
  logic                   status_ok_seen, status_ok_seen_next;
  logic                   in_frame, in_frame_next;
  logic [10:0]            frame_position, frame_position_next;
  logic [10:0]            frame_total, frame_total_next;

  out_item_t              res;
  logic                   res_valid;
  logic                   take;

  logic [WIN_LEN*8-1:0]   win_shift;
  logic [CW-1:0]          count_inc;
  logic                   status_hit, status_now, term_hit;
  logic [11:0]            pos_inc;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign win_shift  = {tail_window[(WIN_LEN-1)*8-1:0], in_data.rx_byte};
  assign count_inc  = header_count + CW'(1);
  assign status_hit = (win_shift[55:0] == ICY_TEXT) || (win_shift == HTTP11_TEXT)
                   || (win_shift == HTTP10_TEXT);
  assign status_now = status_ok_seen || status_hit;
  assign term_hit   = (win_shift[31:0] == TERM_TEXT);
  assign pos_inc    = {1'b0, frame_position} + 12'd1;

  always_comb begin
    header_phase_next   = header_phase;
    header_count_next   = header_count;
    tail_window_next    = tail_window;
    status_ok_seen_next = status_ok_seen;
    in_frame_next       = in_frame;
    frame_position_next = frame_position;
    frame_total_next    = frame_total;
    res                 = '0;

    if (in_data.func == FUNC_RESTART) begin
      res.frame_abort     = in_frame;
      header_phase_next   = 1'b1;
      header_count_next   = '0;
      tail_window_next    = '0;
      status_ok_seen_next = 1'b0;
      in_frame_next       = 1'b0;
      frame_position_next = '0;
      frame_total_next    = '0;
    end else if (header_phase) begin
      tail_window_next    = win_shift;
      header_count_next   = count_inc;
      status_ok_seen_next = status_now;
      if (term_hit) begin
        res.event_res       = status_now ? EV_STATUS_OK : EV_REJECT;
        header_phase_next   = !status_now;
        header_count_next   = '0;
        tail_window_next    = '0;
        status_ok_seen_next = 1'b0;
      end else if (in_data.rx_byte == PREAMBLE) begin
        res.event_res       = EV_PREAMBLE;
        res.has_byte        = 1'b1;
        res.out_byte        = in_data.rx_byte;
        res.frame_first     = 1'b1;
        header_phase_next   = 1'b0;
        header_count_next   = '0;
        tail_window_next    = '0;
        status_ok_seen_next = 1'b0;
        in_frame_next       = 1'b1;
        frame_position_next = 11'd1;
        frame_total_next    = '0;
      end else if (count_inc >= CW'(HEADER_MAX)) begin
        res.event_res       = EV_TOO_LONG;
        header_count_next   = '0;
        tail_window_next    = '0;
        status_ok_seen_next = 1'b0;
      end
    end else if (!in_frame) begin
      if (in_data.rx_byte == PREAMBLE) begin
        res.has_byte        = 1'b1;
        res.out_byte        = in_data.rx_byte;
        res.frame_first     = 1'b1;
        in_frame_next       = 1'b1;
        frame_position_next = 11'd1;
        frame_total_next    = '0;
      end
    end else begin
      res.has_byte        = 1'b1;
      res.out_byte        = in_data.rx_byte;
      frame_position_next = pos_inc[10:0];
      if (frame_position == 11'd1) begin
        frame_total_next = {1'b0, in_data.rx_byte[1:0] & LEN_HI_MASK[1:0], 8'd0};
      end else if (frame_position == 11'd2) begin
        frame_total_next = (frame_total | {3'd0, in_data.rx_byte}) + 11'(FRAME_EXTRA);
      end else if (pos_inc >= {1'b0, frame_total}) begin
        res.frame_last      = 1'b1;
        in_frame_next       = 1'b0;
        frame_position_next = '0;
      end
    end
  end

  assign res_valid = res.has_byte || res.frame_abort || (res.event_res != EV_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_phase   <= 1'b1;
      header_count   <= '0;
      tail_window    <= '0;
      status_ok_seen <= 1'b0;
      in_frame       <= 1'b0;
      frame_position <= '0;
      frame_total    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        header_phase   <= header_phase_next;
        header_count   <= header_count_next;
        tail_window    <= tail_window_next;
        status_ok_seen <= status_ok_seen_next;
        in_frame       <= in_frame_next;
        frame_position <= frame_position_next;
        frame_total    <= frame_total_next;
      end
      // hold the result until taken; refill only when the register frees
      if (in_ready) begin
        out_valid <= take && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= res;
    end
  end

  a_frame_not_in_header: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> !header_phase)
    else $error("frame open during header phase");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    header_count < CW'(HEADER_MAX))
    else $error("header count past limit");

  a_first_last_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.frame_first && out_data.frame_last))
    else $error("item marked first and last");

  a_empty_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.has_byte) |->
      (out_data.out_byte == 8'd0 && !out_data.frame_first && !out_data.frame_last))
    else $error("non-byte item carries byte data");

  a_header_clears_frame: assert property (@(posedge clk) disable iff (rst)
    (take && in_data.func == FUNC_RESTART) |=> (header_phase && !in_frame))
    else $error("restart did not return to header phase");

endmodule
